// File: src/vfr_pkg.sv
// Shared mode codes and the fixed action field width for the viewport fit rectangle unit.
package vfr_pkg;

	localparam int ACTION_BITS = 2;

	typedef enum logic [ACTION_BITS-1:0] {
		MODE_STRETCH = 2'd0,
		MODE_PIXEL   = 2'd1,
		MODE_ASPECT  = 2'd2
	} mode_t;

endpackage

// File: src/vfr_if.sv
// Valid/ready channel interfaces for request and result beats.
interface vfr_req_if #(parameter int DIM_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic [vfr_pkg::ACTION_BITS-1:0]  action;
	logic [DIM_BITS-1:0]              src_width;
	logic [DIM_BITS-1:0]              src_height;
	logic [DIM_BITS-1:0]              out_width;
	logic [DIM_BITS-1:0]              out_height;

	modport source (output valid, action, src_width, src_height, out_width, out_height,
		input ready);
	modport sink (input valid, action, src_width, src_height, out_width, out_height,
		output ready);
endinterface

interface vfr_rsp_if #(parameter int DIM_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [DIM_BITS-1:0]  rect_x;
	logic [DIM_BITS-1:0]  rect_y;
	logic [DIM_BITS-1:0]  rect_width;
	logic [DIM_BITS-1:0]  rect_height;

	modport source (output valid, rect_x, rect_y, rect_width, rect_height, input ready);
	modport sink (input valid, rect_x, rect_y, rect_width, rect_height, output ready);
endinterface

// File: src/vfr_div_cell.sv
// One restoring-division cell: produces one quotient bit on two lanes per cycle while en is high.
module vfr_div_cell #(
	parameter int W = 16,
	parameter type side_t = logic
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_i,
	input  side_t              side_i,
	input  logic [1:0][W-1:0]  rem_i,
	input  logic [1:0][W-1:0]  low_i,
	input  logic [1:0][W-1:0]  dv_i,
	input  logic [1:0][W-1:0]  q_i,
	output logic               valid_o,
	output side_t              side_o,
	output logic [1:0][W-1:0]  rem_o,
	output logic [1:0][W-1:0]  low_o,
	output logic [1:0][W-1:0]  dv_o,
	output logic [1:0][W-1:0]  q_o
);

	logic [1:0][W:0]   trial;
	logic [1:0]        ge;
	logic [1:0][W-1:0] rem_d;

	// Shift in the next dividend bit and subtract where the divisor fits
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_i[l], low_i[l][W-1]};
			ge[l]    = trial[l] >= {1'b0, dv_i[l]};
			rem_d[l] = ge[l] ? W'(trial[l] - {1'b0, dv_i[l]}) : trial[l][W-1:0];
		end
	end

	// Hold valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	// Advance the payload to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			for (int l = 0; l < 2; l++) begin
				rem_o[l] <= rem_d[l];
				low_o[l] <= {low_i[l][W-2:0], 1'b0};
				dv_o[l]  <= dv_i[l];
				q_o[l]   <= {q_i[l][W-2:0], ge[l]};
			end
		end
	end

endmodule

// File: src/viewport_fit_rect_unit.sv
// Top level of the viewport fit rectangle unit.
// Takes one request beat per cycle unless stalled and returns one centered rectangle per
// request, in order. The pipeline registers the cross products, passes through a row of
// DIM_BITS division cells (one quotient bit per cell), then registers the scale selection,
// the scale multiply and the clamp/centering step into the output register. The whole
// pipeline advances together and stalls only while a finished result waits at the output.
module viewport_fit_rect_unit #(
	parameter int DIM_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	vfr_req_if.sink    req,
	vfr_rsp_if.source  rsp
);

	localparam int W = DIM_BITS;

	typedef struct packed {
		logic                 full;
		logic                 pixel;
		logic                 le;
		logic [W-1:0]         ow;
		logic [W-1:0]         oh;
		logic [W-1:0]         sw;
		logic [W-1:0]         sh;
	} side_t;

	logic en;
	logic valid_q;

	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	// Stage 1: register inputs and form the cross products
	logic          valid_s1;
	side_t         side_s1;
	logic [2*W-1:0] prod_w_s1, prod_h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.full  <= (req.src_width == '0) || (req.src_height == '0) ||
				(req.out_width == '0) || (req.out_height == '0) ||
				(req.action == vfr_pkg::MODE_STRETCH);
			side_s1.pixel <= (req.action == vfr_pkg::MODE_PIXEL);
			side_s1.le    <= 1'b0;
			side_s1.ow    <= req.out_width;
			side_s1.oh    <= req.out_height;
			side_s1.sw    <= req.src_width;
			side_s1.sh    <= req.src_height;
			prod_w_s1     <= (2*W)'(req.out_width) * (2*W)'(req.src_height);
			prod_h_s1     <= (2*W)'(req.out_height) * (2*W)'(req.src_width);
		end
	end

	// Set up the dividends and divisors for the cell row
	side_t              side_in;
	logic [1:0][W-1:0]  rem_in, low_in, dv_in;
	logic [2*W-1:0]     dividend;

	always_comb begin
		side_in    = side_s1;
		side_in.le = prod_w_s1 <= prod_h_s1;
		dividend   = side_in.le ? prod_w_s1 : prod_h_s1;
		if (side_s1.pixel) begin
			rem_in[0] = '0;
			low_in[0] = side_s1.ow;
			dv_in[0]  = side_s1.sw;
		end else begin
			rem_in[0] = dividend[2*W-1:W];
			low_in[0] = dividend[W-1:0];
			dv_in[0]  = side_in.le ? side_s1.sw : side_s1.sh;
		end
		rem_in[1] = '0;
		low_in[1] = side_s1.oh;
		dv_in[1]  = side_s1.sh;
	end

	// Row of division cells
	logic               valid_c [0:W];
	side_t              side_c  [0:W];
	logic [1:0][W-1:0]  rem_c   [0:W];
	logic [1:0][W-1:0]  low_c   [0:W];
	logic [1:0][W-1:0]  dv_c    [0:W];
	logic [1:0][W-1:0]  q_c     [0:W];

	assign valid_c[0] = valid_s1;
	assign side_c[0]  = side_in;
	assign rem_c[0]   = rem_in;
	assign low_c[0]   = low_in;
	assign dv_c[0]    = dv_in;
	assign q_c[0]     = '0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		vfr_div_cell #(.W(W), .side_t(side_t)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (valid_c[i]),
			.side_i  (side_c[i]),
			.rem_i   (rem_c[i]),
			.low_i   (low_c[i]),
			.dv_i    (dv_c[i]),
			.q_i     (q_c[i]),
			.valid_o (valid_c[i+1]),
			.side_o  (side_c[i+1]),
			.rem_o   (rem_c[i+1]),
			.low_o   (low_c[i+1]),
			.dv_o    (dv_c[i+1]),
			.q_o     (q_c[i+1])
		);
	end

	// Stage 3: pick the integer scale, keep the fit quotient
	logic          valid_s3;
	side_t         side_s3;
	logic [W-1:0]  scale_s3, quo_s3;
	logic [W-1:0]  qmin;

	always_comb begin
		qmin = (q_c[W][0] < q_c[W][1]) ? q_c[W][0] : q_c[W][1];
		if (qmin == '0) begin
			qmin = W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_c[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3  <= side_c[W];
			scale_s3 <= qmin;
			quo_s3   <= q_c[W][0];
		end
	end

	// Stage 4: scale the source size
	logic          valid_s4;
	side_t         side_s4;
	logic [W-1:0]  quo_s4;
	logic [2*W-1:0] mw_s4, mh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			quo_s4  <= quo_s3;
			mw_s4   <= (2*W)'(side_s3.sw) * (2*W)'(scale_s3);
			mh_s4   <= (2*W)'(side_s3.sh) * (2*W)'(scale_s3);
		end
	end

	// Stage 5: choose, clamp and center the rectangle
	logic [2*W-1:0] w_raw, h_raw;
	logic [W-1:0]   w_fin, h_fin;

	always_comb begin
		priority if (side_s4.full) begin
			w_raw = (2*W)'(side_s4.ow);
			h_raw = (2*W)'(side_s4.oh);
		end else if (side_s4.pixel) begin
			w_raw = mw_s4;
			h_raw = mh_s4;
		end else if (side_s4.le) begin
			w_raw = (2*W)'(side_s4.ow);
			h_raw = (2*W)'(quo_s4);
		end else begin
			w_raw = (2*W)'(quo_s4);
			h_raw = (2*W)'(side_s4.oh);
		end
		w_fin = (w_raw < (2*W)'(side_s4.ow)) ? w_raw[W-1:0] : side_s4.ow;
		h_fin = (h_raw < (2*W)'(side_s4.oh)) ? h_raw[W-1:0] : side_s4.oh;
	end

	logic [W-1:0] rect_x_q, rect_y_q, rect_w_q, rect_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rect_w_q <= w_fin;
			rect_h_q <= h_fin;
			rect_x_q <= W'((side_s4.ow - w_fin) >> 1);
			rect_y_q <= W'((side_s4.oh - h_fin) >> 1);
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.rect_x      = rect_x_q;
	assign rsp.rect_y      = rect_y_q;
	assign rsp.rect_width  = rect_w_q;
	assign rsp.rect_height = rect_h_q;

endmodule

// File: tb/tb_viewport_fit_rect_unit.sv
// Testbench for the viewport fit rectangle unit: directed and random requests, checked in order.
module tb_viewport_fit_rect_unit;

	localparam int DW = 16;
	localparam int LATENCY = DW + 4;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [DW-1:0] x;
		logic [DW-1:0] y;
		logic [DW-1:0] w;
		logic [DW-1:0] h;
	} rect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vfr_req_if #(.DIM_BITS(DW)) req ();
	vfr_rsp_if #(.DIM_BITS(DW)) rsp ();

	viewport_fit_rect_unit #(.DIM_BITS(DW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	rect_t expected_rects[$];
	int mismatches = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	longint cycle_count = 0;

	// Free-running clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Compute the centered rectangle for one request
	function automatic rect_t fit_rect(logic [1:0] mode, logic [DW-1:0] sw, logic [DW-1:0] sh,
		logic [DW-1:0] ow, logic [DW-1:0] oh);
		logic [63:0] w, h, scale, sx, sy, cw, ch;
		rect_t r;
		w = 64'(ow);
		h = 64'(oh);
		if (sw != 0 && sh != 0 && ow != 0 && oh != 0 && mode != vfr_pkg::MODE_STRETCH) begin
			if (mode == vfr_pkg::MODE_PIXEL) begin
				sx = 64'(ow) / 64'(sw);
				sy = 64'(oh) / 64'(sh);
				scale = (sx < sy) ? sx : sy;
				if (scale == 0)
					scale = 64'd1;
				w = 64'(sw) * scale;
				h = 64'(sh) * scale;
			end else begin
				cw = 64'(ow) * 64'(sh);
				ch = 64'(oh) * 64'(sw);
				if (cw <= ch)
					h = cw / 64'(sw);
				else
					w = ch / 64'(sh);
			end
			if (w > 64'(ow))
				w = 64'(ow);
			if (h > 64'(oh))
				h = 64'(oh);
		end
		r.x = DW'((64'(ow) - w) >> 1);
		r.y = DW'((64'(oh) - h) >> 1);
		r.w = DW'(w);
		r.h = DW'(h);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
		mismatches++;
		$display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, what, got, want);
	endtask

	// Drive one request beat and wait until it is taken
	task automatic send_request(logic [1:0] mode, logic [DW-1:0] sw, logic [DW-1:0] sh,
		logic [DW-1:0] ow, logic [DW-1:0] oh);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= mode;
		req.src_width <= sw;
		req.src_height <= sh;
		req.out_width <= ow;
		req.out_height <= oh;
		do @(posedge clk); while (!req.ready);
		expected_rects.push_back(fit_rect(mode, sw, sh, ow, oh));
		beats_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain_results();
		req.valid <= 1'b0;
		while (expected_rects.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// Receiver readiness: random idling, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		rect_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rects.size() == 0) begin
				report_mismatch("unexpected result beat, rect_x", rsp.rect_x, '0);
			end else begin
				want = expected_rects.pop_front();
				if (rsp.rect_x !== want.x) report_mismatch("rect_x", rsp.rect_x, want.x);
				if (rsp.rect_y !== want.y) report_mismatch("rect_y", rsp.rect_y, want.y);
				if (rsp.rect_width !== want.w)
					report_mismatch("rect_width", rsp.rect_width, want.w);
				if (rsp.rect_height !== want.h)
					report_mismatch("rect_height", rsp.rect_height, want.h);
				beats_checked++;
			end
		end
	end

	// Abort on a hang
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [DW-1:0] rand_dim();
		case ($urandom_range(5))
			0: return DW'($urandom_range(15));
			1: return DW'($urandom_range(1023));
			2: return DW'(32'hFFFF - $urandom_range(15));
			default: return DW'($urandom());
		endcase
	endfunction

	// Extremes, every mode and every special case
	task automatic test_directed();
		logic [1:0] m;
		for (int i = 0; i < 4; i++) begin
			m = 2'(i);
			send_request(m, 16'd320, 16'd240, 16'd1920, 16'd1080);
			send_request(m, 16'd0, 16'd240, 16'd640, 16'd480);
			send_request(m, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			send_request(m, 16'd800, 16'd20, 16'd640, 16'd480);
			send_request(m, 16'd1, 16'd1, 16'hFFFF, 16'hFFFE);
		end
		send_request(vfr_pkg::MODE_PIXEL, 16'd200, 16'd700, 16'd640, 16'd480);
		send_request(vfr_pkg::MODE_ASPECT, 16'd640, 16'd480, 16'd0, 16'd0);
		send_request(vfr_pkg::MODE_ASPECT, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
		send_request(vfr_pkg::MODE_ASPECT, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
	endtask

	task automatic test_random(int count);
		logic [1:0] m;
		for (int i = 0; i < count; i++) begin
			m = 2'($urandom_range(3));
			if ($urandom_range(19) == 0)
				send_request(m, rand_dim() & {DW{1'($urandom_range(1))}}, rand_dim(),
					rand_dim(), rand_dim());
			else
				send_request(m, rand_dim() | 16'd1, rand_dim() | 16'd1, rand_dim() | 16'd1,
					rand_dim() | 16'd1);
		end
	endtask

	// Stall the output long enough for the pipeline to back up into the input
	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_cycles = 3 * LATENCY;
		test_random(2 * LATENCY);
		drain_results();
	endtask

	initial begin
		req.valid = 1'b0;
		req.action = vfr_pkg::MODE_STRETCH;
		req.src_width = '0;
		req.src_height = '0;
		req.out_width = '0;
		req.out_height = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 64;
		test_directed();
		test_random(140);
		drain_results();

		send_idle_pct = 64;
		recv_idle_pct = 34;
		test_random(130);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(110);
		test_backpressure();

		$display("covered %0d requests in all modes incl. zero sizes and oversized sources,",
			beats_sent);
		$display("with random idling on both sides and a long output stall; %0d results checked",
			beats_checked);
		if (mismatches == 0 && expected_rects.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
